[sv/ssi_pkg.sv]
// shared constants, types and codes for the sorted set insert block
package ssi_pkg;

    localparam int CAPACITY  = 16;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 5;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic                      we;
        logic [ADDR_W-1:0]         waddr;
        logic signed [VALUE_W-1:0] wdata;
        logic [ADDR_W-1:0]         raddr;
    } t_mem_req;

endpackage

[sv/ssi_ram.sv]
// generic simple dual port ram with registered read
module ssi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ssi_seq.sv]
// search and shift sequencer that edits the sorted store
module ssi_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [ssi_pkg::VALUE_W-1:0] i_value,
    output logic                               o_busy,
    input  logic signed [ssi_pkg::VALUE_W-1:0] i_rdata,
    output ssi_pkg::t_mem_req                  o_mem,
    output logic                               o_res_valid,
    input  logic                               i_res_take,
    output ssi_pkg::t_result                   o_res
);

    ssi_pkg::t_state                     r_state, n_state;
    logic signed [ssi_pkg::VALUE_W-1:0]  r_key, n_key;
    logic [ssi_pkg::CNT_W-1:0]           r_pos, n_pos;
    logic [ssi_pkg::CNT_W-1:0]           r_j, n_j;
    logic [ssi_pkg::CNT_W-1:0]           r_count, n_count;
    ssi_pkg::t_status                    r_status, n_status;
    logic [ssi_pkg::CNT_W-1:0]           j_dec;
    logic                                place;

    assign j_dec = r_j - ssi_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssi_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_j      <= n_j;
        r_status <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_pos       = r_pos;
        n_j         = r_j;
        n_count     = r_count;
        n_status    = r_status;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_pos[ssi_pkg::ADDR_W-1:0];
        o_mem.wdata = r_key;
        o_mem.raddr = r_pos[ssi_pkg::ADDR_W-1:0];
        o_res_valid = 1'b0;
        place       = 1'b0;
        unique case (r_state)
            ssi_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_key   = i_value;
                    n_pos   = '0;
                    n_state = ssi_pkg::S_RD;
                end
            end
            ssi_pkg::S_RD: begin
                if (r_pos >= r_count) begin
                    place = 1'b1;
                end else begin
                    n_state = ssi_pkg::S_CMP;
                end
            end
            ssi_pkg::S_CMP: begin
                if (i_rdata == r_key) begin
                    n_status = ssi_pkg::ST_DUPLICATE;
                    n_state  = ssi_pkg::S_DONE;
                end else if (i_rdata > r_key) begin
                    place = 1'b1;
                end else begin
                    n_pos   = r_pos + ssi_pkg::CNT_W'(1);
                    n_state = ssi_pkg::S_RD;
                end
            end
            ssi_pkg::S_SHRD: begin
                if (r_j > r_pos) begin
                    o_mem.raddr = j_dec[ssi_pkg::ADDR_W-1:0];
                    n_state     = ssi_pkg::S_SHWR;
                end else begin
                    o_mem.we = 1'b1;
                    n_count  = r_count + ssi_pkg::CNT_W'(1);
                    n_state  = ssi_pkg::S_DONE;
                end
            end
            ssi_pkg::S_SHWR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_j[ssi_pkg::ADDR_W-1:0];
                o_mem.wdata = i_rdata;
                n_j         = j_dec;
                n_state     = ssi_pkg::S_SHRD;
            end
            ssi_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ssi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssi_pkg::S_IDLE;
            end
        endcase
        // slot found: refuse when full, else start shifting from the top
        if (place) begin
            if (r_count >= ssi_pkg::CAP_CNT) begin
                n_status = ssi_pkg::ST_FULL;
                n_state  = ssi_pkg::S_DONE;
            end else begin
                n_status = ssi_pkg::ST_INSERTED;
                n_j      = r_count;
                n_state  = ssi_pkg::S_SHRD;
            end
        end
    end

    assign o_busy         = (r_state != ssi_pkg::S_IDLE);
    assign o_res.status   = r_status;
    assign o_res.position = r_pos;
    assign o_res.count    = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ssi_pkg::CAP_CNT)
        else $error("element count above capacity");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ssi_pkg::S_IDLE) |-> (r_pos <= r_count))
        else $error("search position beyond element count");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssi_pkg::S_SHWR) |-> (r_j > r_pos && r_j < ssi_pkg::CAP_CNT))
        else $error("shift write outside the moved range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_take && r_status != ssi_pkg::ST_INSERTED)
        |=> (r_count == $past(r_count)))
        else $error("count changed on a refused or duplicate request");

endmodule

[sv/sorted_set_insert_top.sv]
// top level of the sorted set insert block with result register
// Keeps up to CAPACITY distinct signed values in ascending order in one ram
// with a single read and a single write port. Each request scans the store
// from index zero until it meets an equal or larger entry or the end of the
// stored entries. An equal entry is reported as a duplicate; if the store is
// full the request is refused; otherwise each higher entry moves up one place
// and the new value is written. Examined and moved entries together never
// exceed CAPACITY + 1. The pace is set by the single ram read port with its
// registered read. A new request is taken once the previous one has handed
// its result to the output register, which holds it while the downstream
// side stalls. The store needs no clearing after reset: only entries below
// the count are read.
module sorted_set_insert_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [ssi_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ssi_pkg::STATUS_W-1:0]       o_status,
    output logic [ssi_pkg::OUT_IDX_W-1:0]      o_position,
    output logic [ssi_pkg::OUT_IDX_W-1:0]      o_count
);

    ssi_pkg::t_mem_req                   mem_req;
    logic signed [ssi_pkg::VALUE_W-1:0]  rdata;
    logic                                busy;
    logic                                res_valid;
    logic                                res_take;
    ssi_pkg::t_result                    res;
    logic                                r_out_valid;
    ssi_pkg::t_result                    r_out;
    logic [ssi_pkg::CNT_W+ssi_pkg::OUT_IDX_W-1:0] pos_ext;
    logic [ssi_pkg::CNT_W+ssi_pkg::OUT_IDX_W-1:0] cnt_ext;

    ssi_ram #(
        .WIDTH(ssi_pkg::VALUE_W),
        .DEPTH(ssi_pkg::CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_req.we),
        .i_waddr(mem_req.waddr),
        .i_wdata(mem_req.wdata),
        .i_raddr(mem_req.raddr),
        .o_rdata(rdata)
    );

    ssi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_value    (i_value),
        .o_busy     (busy),
        .i_rdata    (rdata),
        .o_mem      (mem_req),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res)
    );

    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign pos_ext = {{ssi_pkg::OUT_IDX_W{1'b0}}, r_out.position};
    assign cnt_ext = {{ssi_pkg::OUT_IDX_W{1'b0}}, r_out.count};

    assign o_stall    = busy;
    assign o_valid    = r_out_valid;
    assign o_status   = r_out.status;
    assign o_position = pos_ext[ssi_pkg::OUT_IDX_W-1:0];
    assign o_count    = cnt_ext[ssi_pkg::OUT_IDX_W-1:0];

endmodule
